// File: rtl/tkd_pkg.sv
// Package of shared types, constants and helper functions for the timekeeper block.
package tkd_pkg;

    // Time constants.
    localparam logic [31:0] MICRO_PER_SEC = 32'd1000000;
    localparam logic [31:0] BASE_RATE_DIV = 32'd50;
    localparam logic [31:0] NEAR_MICRO    = 32'd20000;
    localparam logic [31:0] MIN_DELAY     = 32'd100;
    localparam logic [31:0] FREQ_RESET    = 32'd66666666;

    // Widths of the shared multiply-divide unit.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    // Operation codes of an input item.
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_PLAN   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_CORR = 1'b1;

    // Input item.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] counter_value;
        logic [31:0] set_secs;
        logic [19:0] set_micro;
        logic [31:0] waste_ticks;
        logic        wall_due_valid;
        logic [31:0] wall_due_secs;
        logic [19:0] wall_due_micro;
        logic        run_due_valid;
        logic [31:0] run_due_secs;
        logic [19:0] run_due_micro;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [31:0]        wall_secs;
        logic [31:0]        wall_micro;
        logic [31:0]        run_secs;
        logic [31:0]        run_micro;
        logic [63:0]        ticks_total;
        logic               delay_valid;
        logic signed [31:0] delay_ticks;
        logic [31:0]        expected_count;
    } out_item_t;

    // Request to the multiply-divide unit: quotient of a*b by d.
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [31:0]        d;
    } md_req_t;

    // Response of the multiply-divide unit.
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } md_rsp_t;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD_ACC,
        ST_UPD_SEC,
        ST_UPD_RUN,
        ST_UPD_WALL,
        ST_SET,
        ST_PLAN_BASE,
        ST_PLAN_WALL,
        ST_PLAN_RUN,
        ST_FIN_ADJ,
        ST_FIN_CLAMP,
        ST_FIN_EXP,
        ST_DONE
    } st_t;

    // States of the multiply-divide unit.
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_st_t;

    // Outcome of comparing one deadline with the current time.
    typedef struct packed {
        logic        neg;
        logic        near;
        logic [19:0] dus;
    } lim_t;

    // Deadline minus current time, with a borrow on the microseconds.
    function automatic lim_t limit_prep(logic [31:0] due_s, logic [19:0] due_us,
                                        logic [31:0] now_s, logic [31:0] now_us);
        logic [31:0] ds;
        logic [31:0] dus;
        lim_t        r;
        ds  = due_s;
        dus = {12'd0, due_us};
        if (now_us > dus)
        begin
            dus = dus + MICRO_PER_SEC;
            ds  = ds - 32'd1;
        end
        dus    = dus - now_us;
        ds     = ds - now_s;
        r.neg  = ds[31];
        r.near = (ds == 32'd0) && (dus < NEAR_MICRO);
        r.dus  = dus[19:0];
        return r;
    endfunction

endpackage

// File: rtl/tkd_muldiv.sv
// Shared iterative unit: one multiply, then a restoring divide one bit per cycle.
module tkd_muldiv (
    input  logic           clk,
    input  logic           rst_n,
    input  tkd_pkg::md_req_t req,
    output tkd_pkg::md_rsp_t rsp
);
    import tkd_pkg::*;

    md_st_t                st_reg, st_next;
    logic [MUL_A_W-1:0]    a_reg;
    logic [MUL_B_W-1:0]    b_reg;
    logic [31:0]           d_reg;
    logic [PROD_W-1:0]     num_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           quot_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [32:0]           trial;
    logic                  qbit;
    logic                  last;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign qbit  = (trial >= {1'b0, d_reg});
    assign last  = (cnt_reg == DIV_CNT_W'(PROD_W - 1));

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            MD_IDLE: if (req.start) st_next = MD_MUL;
            MD_MUL:  st_next = MD_DIV;
            MD_DIV:  if (last) st_next = MD_DONE;
            MD_DONE: st_next = MD_IDLE;
            default: st_next = MD_IDLE;
        endcase
    end

    // Response: a zero divisor yields zero.
    always_comb
    begin
        rsp.done = (st_reg == MD_DONE);
        rsp.quot = (d_reg == 32'd0) ? 32'd0 : quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= MD_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Operand capture, product and divide iterations.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_reg <= req.a;
                    b_reg <= req.b;
                    d_reg <= req.d;
                end
            end
            MD_MUL:
            begin
                num_reg  <= {{MUL_B_W{1'b0}}, a_reg} * {{MUL_A_W{1'b0}}, b_reg};
                rem_reg  <= 32'd0;
                quot_reg <= 32'd0;
                cnt_reg  <= '0;
            end
            MD_DIV:
            begin
                num_reg  <= {num_reg[PROD_W-2:0], 1'b0};
                rem_reg  <= qbit ? 32'(trial - {1'b0, d_reg}) : trial[31:0];
                quot_reg <= {quot_reg[30:0], qbit};
                cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/tick_timekeeper_next_deadline_core.sv
// Top level of the timekeeper: sequencer, time state, configuration port and result register.
//
// Usage: an input item arrives on in_item under in_valid and is taken when in_stall is low.
// op selects a counter update, a wall time set or a plan of the next interrupt; each item
// yields exactly one result item on out_item under out_valid, taken when out_stall is low.
// The block works on one item at a time and holds in_stall high until the item is done.
// All divisions run on one shared unit: a 32x20 multiply followed by a restoring divide
// of 52 steps. A set makes one use of it, an update two conversions and a plan one to
// three uses, while an unused op code makes none and goes straight to its final state.
// The result register parts the output from the sequencer: a stalled result is held
// unchanged while the next item is already being worked on, and a finished item waits
// in its final state until the register is free.
// Reset clears all time state, sets the frequency register to 66666666 and the
// correction to zero, and leaves the output channel empty. The configuration port is an
// APB-style slave, always ready, with the frequency at address 0 and the correction at 4.
module tick_timekeeper_next_deadline_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tkd_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output tkd_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tkd_pkg::*;

    st_t         st_reg, st_next;
    logic        issued_reg, issued_next;
    in_item_t    item_reg;
    logic [31:0] freq_reg;
    logic [31:0] corr_reg;
    logic [31:0] prev_reg, prev_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] wall_acc_reg, wall_acc_next;
    logic [31:0] run_acc_reg, run_acc_next;
    logic [31:0] wall_sec_reg, wall_sec_next;
    logic [31:0] wall_micro_reg, wall_micro_next;
    logic [31:0] run_sec_reg, run_sec_next;
    logic [31:0] run_micro_reg, run_micro_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] delay_reg, delay_next;
    logic [31:0] adj_reg, adj_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        cfg_write;
    logic        out_free;
    logic [31:0] diff;
    logic [31:0] dtmp;
    lim_t        lp;
    md_req_t     md_req;
    md_rsp_t     md_rsp;

    tkd_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Handshakes.
    assign in_stall  = (st_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_FREQ: prdata = freq_reg;
            REG_CORR: prdata = corr_reg;
            default:  prdata = 32'd0;
        endcase
    end

    // Deadline comparison for the deadline under work.
    always_comb
    begin
        if (st_reg == ST_PLAN_RUN)
        begin
            lp = limit_prep(item_reg.run_due_secs, item_reg.run_due_micro,
                            run_sec_reg, run_micro_reg);
        end
        else
        begin
            lp = limit_prep(item_reg.wall_due_secs, item_reg.wall_due_micro,
                            wall_sec_reg, wall_micro_reg);
        end
    end

    assign diff = item_reg.counter_value - prev_reg;
    assign dtmp = delay_reg - adj_reg;

    // Next state of the sequencer.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.op)
                        OP_UPDATE: st_next = ST_UPD_ACC;
                        OP_SET:    st_next = ST_SET;
                        OP_PLAN:   st_next = ST_PLAN_BASE;
                        default:   st_next = ST_DONE;
                    endcase
                end
            end
            ST_UPD_ACC:   st_next = ST_UPD_SEC;
            ST_UPD_SEC:   st_next = ST_UPD_RUN;
            ST_UPD_RUN:   if (md_rsp.done) st_next = ST_UPD_WALL;
            ST_UPD_WALL:  if (md_rsp.done) st_next = ST_DONE;
            ST_SET:       if (md_rsp.done) st_next = ST_DONE;
            ST_PLAN_BASE: if (md_rsp.done) st_next = ST_PLAN_WALL;
            ST_PLAN_WALL:
            begin
                if (!item_reg.wall_due_valid || lp.neg || !lp.near || md_rsp.done)
                    st_next = ST_PLAN_RUN;
            end
            ST_PLAN_RUN:
            begin
                if (!item_reg.run_due_valid || lp.neg || !lp.near || md_rsp.done)
                    st_next = ST_FIN_ADJ;
            end
            ST_FIN_ADJ:   st_next = ST_FIN_CLAMP;
            ST_FIN_CLAMP: st_next = ST_FIN_EXP;
            ST_FIN_EXP:   st_next = ST_DONE;
            ST_DONE:      if (out_free) st_next = ST_IDLE;
            default:      st_next = ST_IDLE;
        endcase
    end

    // Datapath: unit requests and next values of the time state.
    always_comb
    begin
        issued_next     = issued_reg;
        prev_next       = prev_reg;
        total_next      = total_reg;
        wall_acc_next   = wall_acc_reg;
        run_acc_next    = run_acc_reg;
        wall_sec_next   = wall_sec_reg;
        wall_micro_next = wall_micro_reg;
        run_sec_next    = run_sec_reg;
        run_micro_next  = run_micro_reg;
        expected_next   = expected_reg;
        delay_next      = delay_reg;
        adj_next        = adj_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        md_req.start    = 1'b0;
        md_req.a        = freq_reg;
        md_req.b        = 20'd1;
        md_req.d        = MICRO_PER_SEC;

        case (st_reg)
            ST_UPD_ACC:
            begin
                prev_next     = item_reg.counter_value;
                total_next    = total_reg + {32'd0, diff};
                wall_acc_next = wall_acc_reg + diff;
                run_acc_next  = run_acc_reg + diff;
            end
            ST_UPD_SEC:
            begin
                // Each accumulator gives up at most one second per update.
                if (wall_acc_reg >= freq_reg)
                begin
                    wall_acc_next = wall_acc_reg - freq_reg;
                    wall_sec_next = wall_sec_reg + 32'd1;
                end
                if (run_acc_reg >= freq_reg)
                begin
                    run_acc_next = run_acc_reg - freq_reg;
                    run_sec_next = run_sec_reg + 32'd1;
                end
            end
            ST_UPD_RUN:
            begin
                md_req.start = !issued_reg;
                md_req.a     = run_acc_reg;
                md_req.b     = MICRO_PER_SEC[19:0];
                md_req.d     = freq_reg;
                issued_next  = !md_rsp.done;
                if (md_rsp.done)
                    run_micro_next = md_rsp.quot;
            end
            ST_UPD_WALL:
            begin
                md_req.start = !issued_reg;
                md_req.a     = wall_acc_reg;
                md_req.b     = MICRO_PER_SEC[19:0];
                md_req.d     = freq_reg;
                issued_next  = !md_rsp.done;
                if (md_rsp.done)
                    wall_micro_next = md_rsp.quot;
            end
            ST_SET:
            begin
                md_req.start = !issued_reg;
                md_req.b     = item_reg.set_micro;
                issued_next  = !md_rsp.done;
                if (md_rsp.done)
                begin
                    wall_sec_next   = item_reg.set_secs;
                    wall_micro_next = {12'd0, item_reg.set_micro};
                    wall_acc_next   = md_rsp.quot;
                end
            end
            ST_PLAN_BASE:
            begin
                md_req.start = !issued_reg;
                md_req.d     = BASE_RATE_DIV;
                issued_next  = !md_rsp.done;
                if (md_rsp.done)
                    delay_next = md_rsp.quot;
            end
            ST_PLAN_WALL, ST_PLAN_RUN:
            begin
                // A past deadline zeroes the delay; a near one may shorten it.
                if ((st_reg == ST_PLAN_WALL) ? item_reg.wall_due_valid
                                             : item_reg.run_due_valid)
                begin
                    if (lp.neg)
                    begin
                        delay_next = 32'd0;
                    end
                    else if (lp.near)
                    begin
                        md_req.start = !issued_reg;
                        md_req.b     = lp.dus;
                        issued_next  = !md_rsp.done;
                        if (md_rsp.done && (delay_reg > md_rsp.quot))
                            delay_next = md_rsp.quot;
                    end
                end
            end
            ST_FIN_ADJ:
            begin
                adj_next = item_reg.counter_value - item_reg.waste_ticks + corr_reg;
            end
            ST_FIN_CLAMP:
            begin
                delay_next = ($signed(dtmp) < $signed(MIN_DELAY)) ? MIN_DELAY : dtmp;
            end
            ST_FIN_EXP:
            begin
                expected_next = item_reg.counter_value + delay_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.wall_secs      = wall_sec_reg;
                    out_next.wall_micro     = wall_micro_reg;
                    out_next.run_secs       = run_sec_reg;
                    out_next.run_micro      = run_micro_reg;
                    out_next.ticks_total    = total_reg;
                    out_next.delay_valid    = (item_reg.op == OP_PLAN);
                    out_next.delay_ticks    = (item_reg.op == OP_PLAN) ? $signed(delay_reg)
                                                                       : 32'sd0;
                    out_next.expected_count = expected_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and time state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            issued_reg     <= 1'b0;
            freq_reg       <= FREQ_RESET;
            corr_reg       <= 32'd0;
            prev_reg       <= 32'd0;
            total_reg      <= 64'd0;
            wall_acc_reg   <= 32'd0;
            run_acc_reg    <= 32'd0;
            wall_sec_reg   <= 32'd0;
            wall_micro_reg <= 32'd0;
            run_sec_reg    <= 32'd0;
            run_micro_reg  <= 32'd0;
            expected_reg   <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            issued_reg     <= issued_next;
            prev_reg       <= prev_next;
            total_reg      <= total_next;
            wall_acc_reg   <= wall_acc_next;
            run_acc_reg    <= run_acc_next;
            wall_sec_reg   <= wall_sec_next;
            wall_micro_reg <= wall_micro_next;
            run_sec_reg    <= run_sec_next;
            run_micro_reg  <= run_micro_next;
            expected_reg   <= expected_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_FREQ: freq_reg <= pwdata;
                    REG_CORR: corr_reg <= pwdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
        delay_reg <= delay_next;
        adj_reg   <= adj_next;
        out_reg   <= out_next;
    end

endmodule

// File: rtl/tkd_checker.sv
// Port-level checker for the timekeeper top level, with its bind statement.
module tkd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  tkd_pkg::out_item_t out_item
);
    import tkd_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result item changed or vanished");

    // Once an item is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // Results other than a plan carry no delay.
    a_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.delay_valid |-> out_item.delay_ticks == 32'sd0)
        else $error("delay reported on a result that is not a plan");

    // A planned delay is never below the minimum.
    a_min_delay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.delay_valid |-> out_item.delay_ticks >= $signed(MIN_DELAY))
        else $error("planned delay below the minimum");

endmodule

bind tick_timekeeper_next_deadline_core tkd_checker u_tkd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
